/* hw/rtl/rthd_pkg.sv */
// Shared types, constants and the arctangent step table for the hue pipeline.
`default_nettype none
package rthd_pkg;

  localparam int VEC_SHIFT    = 32;
  localparam int SQRT3_BITS   = 33;
  localparam logic [SQRT3_BITS-1:0] SQRT3_SCALED = 33'd7439101574;
  localparam int CORDIC_STEPS = 22;
  localparam int ANGLE_BITS   = 25;
  localparam int PHI_BITS     = 26;
  localparam int ANGLE_FRAC   = 16;
  localparam int HUE_BITS     = 9;
  localparam int SECTOR_BITS  = 4;

  localparam logic signed [ANGLE_BITS-1:0] ANGLE_90  = 25'sd5898240;
  localparam logic signed [PHI_BITS-1:0]   ANGLE_180 = 26'sd11796480;
  localparam logic signed [PHI_BITS-1:0]   ANGLE_360 = 26'sd23592960;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] sector;
    logic                   xneg;
    logic                   yneg;
    logic                   undef;
  } rthd_ctrl_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [ANGLE_BITS-1:0] atan_step(input int i);
    logic signed [ANGLE_BITS-1:0] v;
    case (i)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117304;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rthd_if.sv */
// Handshake interfaces for the color sample and hue result channels.
`default_nettype none
interface rthd_rgb_if #(parameter int CHANNEL_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rthd_hue_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic       undefined_hue;
  modport source (output valid, hue, undefined_hue, input ready);
  modport sink   (input valid, hue, undefined_hue, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rthd_cordic_pair.sv */
// Two registered CORDIC vectoring iterations.
`default_nettype none
module rthd_cordic_pair
  import rthd_pkg::*;
#(
  parameter int VW    = 54,
  parameter int FIRST = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [VW-1:0]         in_vx,
  input  wire logic signed [VW-1:0]         in_vy,
  input  wire logic signed [ANGLE_BITS-1:0] in_z,
  input  wire rthd_ctrl_t                   in_ctrl,
  output logic                              out_valid,
  output logic signed [VW-1:0]              out_vx,
  output logic signed [VW-1:0]              out_vy,
  output logic signed [ANGLE_BITS-1:0]      out_z,
  output rthd_ctrl_t                        out_ctrl
);

  logic signed [VW-1:0]         vx_mid, vy_mid, vx_next, vy_next;
  logic signed [ANGLE_BITS-1:0] z_mid, z_next;

  // rotate toward the first axis; a zero vy leaves the vector alone
  always_comb begin
    vx_mid = in_vx;
    vy_mid = in_vy;
    z_mid  = in_z;
    if (in_vy > 0) begin
      vx_mid = in_vx + (in_vy >>> FIRST);
      vy_mid = in_vy - (in_vx >>> FIRST);
      z_mid  = in_z + atan_step(FIRST);
    end else if (in_vy < 0) begin
      vx_mid = in_vx - (in_vy >>> FIRST);
      vy_mid = in_vy + (in_vx >>> FIRST);
      z_mid  = in_z - atan_step(FIRST);
    end
    vx_next = vx_mid;
    vy_next = vy_mid;
    z_next  = z_mid;
    if (vy_mid > 0) begin
      vx_next = vx_mid + (vy_mid >>> (FIRST + 1));
      vy_next = vy_mid - (vx_mid >>> (FIRST + 1));
      z_next  = z_mid + atan_step(FIRST + 1);
    end else if (vy_mid < 0) begin
      vx_next = vx_mid - (vy_mid >>> (FIRST + 1));
      vy_next = vy_mid + (vx_mid >>> (FIRST + 1));
      z_next  = z_mid - atan_step(FIRST + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_vx   <= vx_next;
      out_vy   <= vy_next;
      out_z    <= z_next;
      out_ctrl <= in_ctrl;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rgb_to_hue_degrees_unit.sv */
// Top level: pipelined HSI hue in whole degrees from one red, green, blue sample.
`default_nettype none
// Each sample is converted independently; one item enters per clock and one
// result leaves per clock unless the output stalls. The stages are the sector and
// difference stage, scaling multiply stage, eleven stages of two CORDIC
// iterations each, and the output mapping stage. The whole pipeline shares
// one advance enable: it moves whenever the output register is empty or being
// taken, so a stalled result holds every stage behind it. Hue is 0..359
// degrees, truncated; when all three channels are equal the hue is 0 and
// undefined_hue is set.
module rgb_to_hue_degrees_unit
  import rthd_pkg::*;
#(
  parameter int CHANNEL_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  rthd_rgb_if.sink   sample,
  rthd_hue_if.source result
);

  localparam int XW     = CHANNEL_BITS + 4;   // 2R-G-B and 3*y
  localparam int MW     = CHANNEL_BITS + 1;   // |x| magnitude
  localparam int VW     = CHANNEL_BITS + 38;  // CORDIC vector
  localparam int PAIRS  = CORDIC_STEPS / 2;

  // advance all stages together
  logic en;
  assign en = !result.valid || result.ready;
  assign sample.ready = en;

  // ---- stage 1: differences and exact 30-degree sector
  logic signed [XW-1:0] x_c, y_c, ny_c;
  logic [SECTOR_BITS-1:0] sector_c;
  rthd_ctrl_t           ctrl_c;
  logic                 s1_valid;
  rthd_ctrl_t           s1_ctrl;
  logic [MW-1:0]        s1_ax;
  logic [CHANNEL_BITS-1:0] s1_ay;

  always_comb begin
    x_c  = (XW'(sample.red) <<< 1) - XW'(sample.green) - XW'(sample.blue);
    y_c  = XW'(sample.green) - XW'(sample.blue);
    ny_c = -y_c;
    if (y_c > 0) begin
      sector_c = SECTOR_BITS'(x_c <= 3 * y_c) + SECTOR_BITS'(x_c <= y_c)
               + SECTOR_BITS'(x_c <= 0) + SECTOR_BITS'(x_c <= ny_c)
               + SECTOR_BITS'(x_c <= 3 * ny_c);
    end else if (y_c < 0) begin
      sector_c = SECTOR_BITS'(6) + SECTOR_BITS'(x_c >= -3 * ny_c)
               + SECTOR_BITS'(x_c >= y_c) + SECTOR_BITS'(x_c >= 0)
               + SECTOR_BITS'(x_c >= ny_c) + SECTOR_BITS'(x_c >= 3 * ny_c);
    end else begin
      sector_c = (x_c > 0) ? SECTOR_BITS'(0) : SECTOR_BITS'(6);
    end
    ctrl_c.sector = sector_c;
    ctrl_c.xneg   = x_c[XW-1];
    ctrl_c.yneg   = y_c[XW-1];
    ctrl_c.undef  = (x_c == 0) && (y_c == 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample.valid;
    end
    if (en) begin
      s1_ctrl <= ctrl_c;
      s1_ax   <= MW'(x_c[XW-1] ? -x_c : x_c);
      s1_ay   <= CHANNEL_BITS'(y_c[XW-1] ? ny_c : y_c);
    end
  end

  // ---- stage 2: scale to the CORDIC vector, y by sqrt(3)
  logic                         pv [0:PAIRS];
  logic signed [VW-1:0]         pvx [0:PAIRS];
  logic signed [VW-1:0]         pvy [0:PAIRS];
  logic signed [ANGLE_BITS-1:0] pz [0:PAIRS];
  rthd_ctrl_t                   pc [0:PAIRS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (en) begin
      pv[0] <= s1_valid;
    end
    if (en) begin
      pvx[0] <= VW'({s1_ax, {VEC_SHIFT{1'b0}}});
      pvy[0] <= VW'(s1_ay * SQRT3_SCALED);
      pz[0]  <= '0;
      pc[0]  <= s1_ctrl;
    end
  end

  // ---- CORDIC: two iterations per stage
  for (genvar k = 0; k < PAIRS; k++) begin : g_cordic
    rthd_cordic_pair #(.VW(VW), .FIRST(2 * k)) u_pair (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pv[k]),
      .in_vx     (pvx[k]),
      .in_vy     (pvy[k]),
      .in_z      (pz[k]),
      .in_ctrl   (pc[k]),
      .out_valid (pv[k+1]),
      .out_vx    (pvx[k+1]),
      .out_vy    (pvy[k+1]),
      .out_z     (pz[k+1]),
      .out_ctrl  (pc[k+1])
    );
  end

  // ---- final stage: clamp, map to full circle, floor, clamp into sector
  // The full-circle angle reaches 360 degrees, so it carries one more bit.
  logic signed [ANGLE_BITS-1:0] a_c;
  logic signed [PHI_BITS-1:0]   phi_c;
  logic [9:0]                   deg_c, lo_c, hi_c;
  rthd_ctrl_t                   fc;

  always_comb begin
    fc  = pc[PAIRS];
    a_c = pz[PAIRS];
    if (a_c < 0) a_c = '0;
    if (a_c > ANGLE_90) a_c = ANGLE_90;
    if (!fc.xneg && !fc.yneg) phi_c = PHI_BITS'(a_c);
    else if (fc.xneg && !fc.yneg) phi_c = ANGLE_180 - PHI_BITS'(a_c);
    else if (fc.xneg) phi_c = ANGLE_180 + PHI_BITS'(a_c);
    else phi_c = ANGLE_360 - PHI_BITS'(a_c);
    deg_c = 10'(phi_c[PHI_BITS-1:ANGLE_FRAC]);
    lo_c  = 10'(fc.sector) * 10'd30;
    hi_c  = lo_c + 10'd29;
    if (deg_c < lo_c) deg_c = lo_c;
    if (deg_c > hi_c) deg_c = hi_c;
    if (fc.undef) deg_c = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= pv[PAIRS];
    end
    if (en) begin
      result.hue           <= HUE_BITS'(deg_c);
      result.undefined_hue <= fc.undef;
    end
  end

  // ---- checks
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.undefined_hue |-> result.hue == '0)
    else $error("undefined hue with nonzero angle");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.hue <= HUE_BITS'(359))
    else $error("hue out of range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire
